>>> rtl/memory_type_range_lookup_macros.svh
// Assertion macros used by memory_type_range_lookup. They vanish in synthesis builds.
`ifndef MEMORY_TYPE_RANGE_LOOKUP_MACROS_SVH
`define MEMORY_TYPE_RANGE_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MTRL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("memory_type_range_lookup: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MTRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("memory_type_range_lookup: assertion failed");

`else

`define MTRL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MTRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/mtrl_pkg.sv
package mtrl_pkg;

  localparam int RANGE_SLOTS = 8;
  localparam int FIXED_WORDS = 11;
  localparam int ADDR_W      = 52;
  localparam int PAGE_LSB    = 12;
  localparam int PAGE_W      = ADDR_W - PAGE_LSB;
  localparam int TYPE_W      = 8;
  localparam int FIXED_IDX_W = $clog2(FIXED_WORDS);
  localparam int FIXED_SPAN_W = 20;  // fixed entries cover the first 1 MiB

  // Command codes.
  localparam logic [1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [1:0] CMD_WRITE_FIX  = 2'd1;
  localparam logic [1:0] CMD_WRITE_BASE = 2'd2;
  localparam logic [1:0] CMD_WRITE_MASK = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIXED_PRESENT = 2'd0;
  localparam logic [1:0] CFG_RANGE_COUNT   = 2'd1;
  localparam logic [1:0] CFG_FALLBACK_TYPE = 2'd2;

  // Memory type codes that take part in the merge.
  localparam logic [TYPE_W-1:0] TYPE_UC = 8'd0;
  localparam logic [TYPE_W-1:0] TYPE_WT = 8'd4;
  localparam logic [TYPE_W-1:0] TYPE_WB = 8'd6;

  // Result source codes.
  localparam logic [1:0] SRC_FIXED   = 2'd0;
  localparam logic [1:0] SRC_RANGE   = 2'd1;
  localparam logic [1:0] SRC_DEFAULT = 2'd2;

  // Lookup token passed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              bypass;  // resolved by the fixed ranges already
    logic              found;
    logic [TYPE_W-1:0] cur;
    logic [PAGE_W-1:0] page;
  } tok_t;

endpackage

>>> rtl/memory_type_range_lookup.sv
// A lookup walks the row of range cells, cell 0 first, and its result is then registered
// in the output register. A new lookup or write to the fixed words and range registers
// is taken only once the previous lookup has left the row; a blocked output stalls the row.
// Reset (rst_n, synchronous, active low) clears all fixed words and ranges, empties the
// cell row and output register, and sets fixed_present 1, range_count 8, default type 0.
module memory_type_range_lookup (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // cmd[1:0], slot[5:2], wdata[69:6], phys_addr[121:70]
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // mem_type[7:0], source[9:8]
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  `include "memory_type_range_lookup_macros.svh"

  localparam int N = mtrl_pkg::RANGE_SLOTS;

  // Input fields.
  logic [1:0]                   in_cmd;
  logic [3:0]                   in_slot;
  logic [63:0]                  in_wdata;
  logic [mtrl_pkg::ADDR_W-1:0]  in_addr;

  assign in_cmd   = in_tdata[1:0];
  assign in_slot  = in_tdata[5:2];
  assign in_wdata = in_tdata[69:6];
  assign in_addr  = in_tdata[121:70];

  // Configuration registers. Writes are always taken at once.
  logic       fixed_present_r;
  logic [3:0] range_count_r;
  logic [7:0] fallback_type_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_present_r <= 1'b1;
      range_count_r   <= 4'd8;
      fallback_type_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mtrl_pkg::CFG_FIXED_PRESENT: fixed_present_r <= cfg_data[0];
        mtrl_pkg::CFG_RANGE_COUNT:   range_count_r   <= cfg_data[3:0];
        mtrl_pkg::CFG_FALLBACK_TYPE: fallback_type_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The row holds at most one lookup token. A new item is taken only when the row is
  // empty, so writes never race a lookup in flight and each lookup sees all earlier
  // writes. The output register lets the next item enter while a result waits.
  mtrl_pkg::tok_t tok [N+1];
  logic [N-1:0]   row_valid;
  logic           busy;
  logic           in_xfer;
  logic           adv;
  logic           out_load;

  assign busy      = |row_valid;
  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;

  // Fixed-range words and their lookup.
  logic                          fix_we;
  logic [mtrl_pkg::TYPE_W-1:0]   fixed_type;
  logic                          fixed_hit;

  assign fix_we = in_xfer && in_cmd == mtrl_pkg::CMD_WRITE_FIX &&
                  32'(in_slot) < 32'(mtrl_pkg::FIXED_WORDS);

  mtrl_fixed u_fixed (
    .clk        (clk),
    .rst_n      (rst_n),
    .we         (fix_we),
    .slot       (in_slot),
    .wdata      (in_wdata),
    .addr       (in_addr[mtrl_pkg::FIXED_SPAN_W-1:0]),
    .fixed_type (fixed_type)
  );

  assign fixed_hit = fixed_present_r &&
                     in_addr[mtrl_pkg::ADDR_W-1:mtrl_pkg::FIXED_SPAN_W] == '0;

  // Head token: an address served by the fixed ranges rides the row untouched.
  always_comb begin
    tok[0].valid  = in_xfer && in_cmd == mtrl_pkg::CMD_LOOKUP;
    tok[0].bypass = fixed_hit;
    tok[0].found  = 1'b0;
    tok[0].cur    = fixed_hit ? fixed_type : mtrl_pkg::TYPE_WB;
    tok[0].page   = in_addr[mtrl_pkg::ADDR_W-1:mtrl_pkg::PAGE_LSB];
  end

  // The row moves unless the token sits in the last cell and the output is blocked.
  assign out_load = tok[N].valid && (!out_tvalid || out_tready);
  assign adv      = !tok[N].valid || out_load;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic en;
    logic we_base;
    logic we_mask;

    // A cell joins the search only when it lies below range_count.
    assign en      = 32'(range_count_r) > 32'(i);
    assign we_base = in_xfer && in_cmd == mtrl_pkg::CMD_WRITE_BASE && 32'(in_slot) == 32'(i);
    assign we_mask = in_xfer && in_cmd == mtrl_pkg::CMD_WRITE_MASK && 32'(in_slot) == 32'(i);

    mtrl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .en      (en),
      .we_base (we_base),
      .we_mask (we_mask),
      .wdata   (in_wdata[mtrl_pkg::ADDR_W-1:0]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );

    assign row_valid[i] = tok[i+1].valid;
  end

  // Output register. The default type is read here, after the walk.
  logic                        out_valid_r;
  logic [mtrl_pkg::TYPE_W-1:0] out_type_r;
  logic [1:0]                  out_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (tok[N].bypass) begin
        out_type_r <= tok[N].cur;
        out_src_r  <= mtrl_pkg::SRC_FIXED;
      end else if (tok[N].found) begin
        out_type_r <= tok[N].cur;
        out_src_r  <= mtrl_pkg::SRC_RANGE;
      end else begin
        out_type_r <= fallback_type_r;
        out_src_r  <= mtrl_pkg::SRC_DEFAULT;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_src_r, out_type_r};

  // Only one lookup may be in flight along the row.
  `MTRL_ASSERT_SAME(a_one_token, clk, rst_n, 1'b1, $countones(row_valid) <= 1)
  // An accepted lookup lands in the first cell on the next edge.
  `MTRL_ASSERT_NEXT(a_head_enters, clk, rst_n, tok[0].valid, tok[1].valid)
  // Input is taken only while the row is empty.
  `MTRL_ASSERT_SAME(a_ready_empty, clk, rst_n, in_tready, row_valid == '0)
  // A valid result never carries an unused source code.
  `MTRL_ASSERT_SAME(a_src_legal, clk, rst_n, out_tvalid,
                    out_src_r == mtrl_pkg::SRC_FIXED || out_src_r == mtrl_pkg::SRC_RANGE ||
                    out_src_r == mtrl_pkg::SRC_DEFAULT)

endmodule

>>> rtl/mtrl_fixed.sv
module mtrl_fixed (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 we,
  input  logic [mtrl_pkg::FIXED_IDX_W-1:0]     slot,
  input  logic [63:0]                          wdata,
  input  logic [mtrl_pkg::FIXED_SPAN_W-1:0]    addr,
  output logic [mtrl_pkg::TYPE_W-1:0]          fixed_type
);

  logic [63:0]                      words_r [mtrl_pkg::FIXED_WORDS];
  logic [mtrl_pkg::FIXED_IDX_W-1:0] widx;
  logic [2:0]                       bidx;
  logic [63:0]                      word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mtrl_pkg::FIXED_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else if (we) begin
      words_r[slot] <= wdata;
    end
  end

  // 64 KiB entries below 512 KiB, 16 KiB entries up to 768 KiB, 4 KiB above.
  always_comb begin
    if (addr[19] == 1'b0) begin
      widx = '0;
      bidx = addr[18:16];
    end else if (addr[18] == 1'b0) begin
      widx = (addr[17] == 1'b0) ? 4'd1 : 4'd2;
      bidx = addr[16:14];
    end else begin
      widx = 4'd3 + {1'b0, addr[17:15]};
      bidx = addr[14:12];
    end
  end

  assign word       = words_r[widx];
  assign fixed_type = word[{bidx, 3'b000} +: mtrl_pkg::TYPE_W];

endmodule

>>> rtl/mtrl_cell.sv
module mtrl_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              en,
  input  logic                              we_base,
  input  logic                              we_mask,
  input  logic [mtrl_pkg::ADDR_W-1:0]       wdata,
  input  mtrl_pkg::tok_t                    tok_in,
  output mtrl_pkg::tok_t                    tok_out
);

  logic [mtrl_pkg::PAGE_W-1:0] base_page_r;
  logic [mtrl_pkg::TYPE_W-1:0] base_type_r;
  logic [mtrl_pkg::PAGE_W-1:0] mask_page_r;
  logic                        mask_valid_r;
  mtrl_pkg::tok_t              tok_r;
  mtrl_pkg::tok_t              tok_nxt;
  logic                        hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_page_r  <= '0;
      base_type_r  <= '0;
      mask_page_r  <= '0;
      mask_valid_r <= 1'b0;
    end else begin
      if (we_base) begin
        base_page_r <= wdata[mtrl_pkg::ADDR_W-1:mtrl_pkg::PAGE_LSB];
        base_type_r <= wdata[mtrl_pkg::TYPE_W-1:0];
      end
      if (we_mask) begin
        mask_page_r  <= wdata[mtrl_pkg::ADDR_W-1:mtrl_pkg::PAGE_LSB];
        mask_valid_r <= wdata[11];
      end
    end
  end

  assign hit = tok_in.valid && !tok_in.bypass && en && mask_valid_r &&
               ((mask_page_r & base_page_r) == (mask_page_r & tok_in.page));

  // UC sticks once found; WT wins over WB; otherwise the later range wins.
  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found = 1'b1;
      if (tok_in.found && tok_in.cur == mtrl_pkg::TYPE_UC) begin
        tok_nxt.cur = mtrl_pkg::TYPE_UC;
      end else if ((base_type_r == mtrl_pkg::TYPE_WT && tok_in.cur == mtrl_pkg::TYPE_WB) ||
                   (tok_in.found && base_type_r == mtrl_pkg::TYPE_WB &&
                    tok_in.cur == mtrl_pkg::TYPE_WT)) begin
        tok_nxt.cur = mtrl_pkg::TYPE_WT;
      end else begin
        tok_nxt.cur = base_type_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
